[src/efs_pkg.sv]
package efs_pkg;

  localparam int QUEUE_DEPTH      = 8;
  localparam int PAYLOAD_CAPACITY = 32;

  localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W     = $clog2(PAYLOAD_CAPACITY + 1);
  localparam int POS_W     = $clog2(PAYLOAD_CAPACITY + 2);
  localparam int IDX_W     = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1;
  localparam int PAY_DEPTH = QUEUE_DEPTH * PAYLOAD_CAPACITY;
  localparam int PAY_AW    = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int BYTE_W   = 8;
  localparam int TOTAL_W  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_POST    = 2'd0,
    OP_GET     = 2'd1,
    OP_HANDLED = 2'd2,
    OP_STATS   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

endpackage

[src/efs_cmd_if.sv]
interface efs_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [efs_pkg::OP_W-1:0]      operation;
  logic [efs_pkg::BYTE_W-1:0]    channel;
  logic [efs_pkg::BYTE_W-1:0]    data_byte;
  logic                          last_byte;

  modport source (output valid, operation, channel, data_byte, last_byte, input ready);
  modport sink   (input valid, operation, channel, data_byte, last_byte, output ready);
endinterface

[src/efs_rsp_if.sv]
interface efs_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [efs_pkg::STATUS_W-1:0]    status;
  logic [efs_pkg::BYTE_W-1:0]      out_channel;
  logic [efs_pkg::LEN_W-1:0]       out_length;
  logic [efs_pkg::BYTE_W-1:0]      out_byte;
  logic                            out_last;
  logic [efs_pkg::CNT_W-1:0]       queue_level;
  logic [efs_pkg::CNT_W-1:0]       queue_peak;
  logic [efs_pkg::TOTAL_W-1:0]     post_tally;
  logic [efs_pkg::TOTAL_W-1:0]     handle_tally;
  logic [efs_pkg::TOTAL_W-1:0]     drop_tally;

  modport source (output valid, status, out_channel, out_length, out_byte, out_last,
                  queue_level, queue_peak, post_tally, handle_tally,
                  drop_tally, input ready);
  modport sink   (input valid, status, out_channel, out_length, out_byte, out_last,
                  queue_level, queue_peak, post_tally, handle_tally,
                  drop_tally, output ready);
endinterface

[src/event_fifo_with_stats.sv]
// Event queue with statistics.
// Commands enter on cmd (valid/ready): post one payload byte, get the oldest
// event, mark an event handled, or read the statistics. Results leave on rsp
// (valid/ready). Each result carries the queue statistics after the command.
// Only the last byte of a post gives a result, in the cycle after it is
// taken. Mark-handled and read-statistics also give one result, in the
// cycle after they are taken. A get on a non-empty queue first fetches the
// event from the payload memory and then delivers one byte per cycle while
// rsp keeps up; the payload memory has a single read port. Commands are
// taken at one per cycle while rsp keeps up and no get is streaming.
// A result waits in the output register while rsp.ready is low, and cmd.ready
// stays low until it is taken; no item is lost.
// Reset clears the queue, the post in progress and all counters. No clearing
// pass is needed: only entries of committed events are ever read.
module event_fifo_with_stats (
  input logic       clk,
  input logic       rst,
  efs_cmd_if.sink   cmd,
  efs_rsp_if.source rsp
);
  import efs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_STREAM = 2'b10
  } state_t;

  // Each metadata entry holds the channel above the length.
  logic [BYTE_W-1:0]       payload_mem [PAY_DEPTH];
  logic [BYTE_W+LEN_W-1:0] meta_mem    [QUEUE_DEPTH];

  state_t              state, state_next;
  logic [SLOT_W-1:0]   write_slot, write_slot_next;
  logic [SLOT_W-1:0]   read_slot, read_slot_next;
  logic [SLOT_W-1:0]   cur_slot;
  logic [CNT_W-1:0]    occupancy, occupancy_next;
  logic [CNT_W-1:0]    peak, peak_next;
  logic [TOTAL_W-1:0]  posted, posted_next;
  logic [TOTAL_W-1:0]  handled, handled_next;
  logic [TOTAL_W-1:0]  dropped, dropped_next;
  logic [POS_W-1:0]    post_pos, post_pos_next;
  logic                discarding, discarding_next;
  logic [IDX_W-1:0]    idx, idx_next;

  logic                out_valid, out_valid_next;
  logic [STATUS_W-1:0] out_status, out_status_next;
  logic [BYTE_W-1:0]   out_chan, out_chan_next;
  logic [LEN_W-1:0]    out_len, out_len_next;
  logic [BYTE_W-1:0]   out_data, out_data_next;
  logic                out_end, out_end_next;

  logic [BYTE_W-1:0]       pay_rdata;
  logic [BYTE_W+LEN_W-1:0] meta_rdata;
  logic [BYTE_W-1:0]       chan_rdata;
  logic [LEN_W-1:0]        len_rdata;
  logic [LEN_W-1:0]        len_eff;
  logic [PAY_AW-1:0]       pay_raddr, pay_waddr;
  logic [SLOT_W-1:0]       meta_raddr;
  logic                    pay_we, meta_we;

  logic                out_free;
  logic                accept;
  logic                disc_now;
  logic [POS_W-1:0]    pos_inc;
  logic                is_last_out;

  assign out_free = !out_valid || rsp.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign accept = cmd.valid && cmd.ready;

  assign disc_now = (post_pos == '0) ? (occupancy >= CNT_W'(QUEUE_DEPTH)) : discarding;
  assign pos_inc = (post_pos <= POS_W'(PAYLOAD_CAPACITY)) ? post_pos + 1'b1 : post_pos;
  assign pay_waddr = PAY_AW'(write_slot * PAYLOAD_CAPACITY) + PAY_AW'(post_pos);
  assign pay_we = accept && (cmd.operation == OP_POST) && !disc_now
                  && (post_pos < POS_W'(PAYLOAD_CAPACITY));

  assign chan_rdata = meta_rdata[BYTE_W+LEN_W-1:LEN_W];
  assign len_rdata  = meta_rdata[LEN_W-1:0];

  // Stored lengths are always in range; the clamp keeps the stream bounded.
  always_comb begin
    if (len_rdata == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_rdata > LEN_W'(PAYLOAD_CAPACITY)) begin
      len_eff = LEN_W'(PAYLOAD_CAPACITY);
    end else begin
      len_eff = len_rdata;
    end
  end

  assign is_last_out = (LEN_W'(idx) + 1'b1) == len_eff;

  // The read address follows the byte index so that the registered read data
  // always belongs to the current index.
  assign meta_raddr = (state == S_IDLE) ? read_slot : cur_slot;
  assign pay_raddr  = PAY_AW'(meta_raddr * PAYLOAD_CAPACITY) + PAY_AW'(idx_next);

  always_comb begin
    state_next      = state;
    write_slot_next = write_slot;
    read_slot_next  = read_slot;
    occupancy_next  = occupancy;
    peak_next       = peak;
    posted_next     = posted;
    handled_next    = handled;
    dropped_next    = dropped;
    post_pos_next   = post_pos;
    discarding_next = discarding;
    idx_next        = idx;
    meta_we         = 1'b0;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_chan_next   = out_chan;
    out_len_next    = out_len;
    out_data_next   = out_data;
    out_end_next    = out_end;

    case (state)
      S_IDLE: begin
        idx_next = '0;
        if (accept) begin
          out_status_next = ST_OK;
          out_chan_next   = '0;
          out_len_next    = '0;
          out_data_next   = '0;
          out_end_next    = 1'b1;
          case (cmd.operation)
            OP_POST: begin
              if (cmd.last_byte) begin
                out_valid_next  = 1'b1;
                post_pos_next   = '0;
                discarding_next = 1'b0;
                if (pos_inc > POS_W'(PAYLOAD_CAPACITY)) begin
                  out_status_next = ST_TOO_LONG;
                end else if (disc_now) begin
                  out_status_next = ST_DROPPED;
                  dropped_next    = dropped + 1'b1;
                end else begin
                  meta_we         = 1'b1;
                  write_slot_next = (write_slot == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : write_slot + 1'b1;
                  occupancy_next  = occupancy + 1'b1;
                  if (occupancy_next > peak) begin
                    peak_next = occupancy_next;
                  end
                  posted_next = posted + 1'b1;
                end
              end else begin
                post_pos_next   = pos_inc;
                discarding_next = disc_now;
              end
            end
            OP_GET: begin
              if (occupancy == '0) begin
                out_valid_next  = 1'b1;
                out_status_next = ST_EMPTY;
              end else begin
                read_slot_next = (read_slot == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : read_slot + 1'b1;
                occupancy_next = occupancy - 1'b1;
                state_next     = S_STREAM;
              end
            end
            OP_HANDLED: begin
              out_valid_next = 1'b1;
              handled_next   = handled + 1'b1;
            end
            default: begin
              out_valid_next = 1'b1;
            end
          endcase
        end
      end
      S_STREAM: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = ST_OK;
          out_chan_next   = chan_rdata;
          out_len_next    = len_eff;
          out_data_next   = pay_rdata;
          out_end_next    = is_last_out;
          if (is_last_out) begin
            idx_next   = '0;
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      payload_mem[pay_waddr] <= cmd.data_byte;
    end
    pay_rdata <= payload_mem[pay_raddr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[write_slot] <= {cmd.channel, LEN_W'(pos_inc)};
    end
    meta_rdata <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_slot <= '0;
      read_slot  <= '0;
      occupancy  <= '0;
      peak       <= '0;
      posted     <= '0;
      handled    <= '0;
      dropped    <= '0;
      post_pos   <= '0;
      discarding <= 1'b0;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      write_slot <= write_slot_next;
      read_slot  <= read_slot_next;
      occupancy  <= occupancy_next;
      peak       <= peak_next;
      posted     <= posted_next;
      handled    <= handled_next;
      dropped    <= dropped_next;
      post_pos   <= post_pos_next;
      discarding <= discarding_next;
      idx        <= idx_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      cur_slot <= read_slot;
    end
    out_status <= out_status_next;
    out_chan   <= out_chan_next;
    out_len    <= out_len_next;
    out_data   <= out_data_next;
    out_end    <= out_end_next;
  end

  // The counters only move when a command is taken, and a command is only
  // taken once the waiting result leaves, so they can drive rsp directly.
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_channel  = out_chan;
  assign rsp.out_length   = out_len;
  assign rsp.out_byte     = out_data;
  assign rsp.out_last     = out_end;
  assign rsp.queue_level  = occupancy;
  assign rsp.queue_peak   = peak;
  assign rsp.post_tally   = posted;
  assign rsp.handle_tally = handled;
  assign rsp.drop_tally   = dropped;

endmodule
